>>> design/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, payload structs, control struct and state encoding for the
// digit-serial DDA line generator.
// ----------------------------------------------------------------------------
package dda_pkg;

    // field widths
    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int COLOUR_BITS = 4;

    // serial datapath: accumulators are added one digit per cycle
    localparam int DIGIT_BITS  = 8;
    localparam int ACC_BITS    = COORD_BITS + FRAC_BITS;
    localparam int ACC_DIGITS  = (ACC_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int ACC_PAD     = ACC_DIGITS * DIGIT_BITS;

    // restoring divider: one integer bit plus one bit per fraction bit
    localparam int DIV_STEPS   = FRAC_BITS + 1;
    localparam int REM_BITS    = COORD_BITS + 1;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    // steps left counter holds up to the longest span
    localparam int STEPS_BITS  = COORD_BITS + 1;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic [COORD_BITS-1:0]  start_x;
        logic [COORD_BITS-1:0]  start_y;
        logic [COORD_BITS-1:0]  end_x;
        logic [COORD_BITS-1:0]  end_y;
        logic [COLOUR_BITS-1:0] colour;
    } item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [COLOUR_BITS-1:0] pixel_colour;
        logic                   last_pixel;
    } pixel_t;

    // control from the sequencer to each axis datapath
    typedef struct packed {
        logic load;
        logic div_en;
        logic div_first;
        logic add_en;
        logic add_first;
    } axis_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_DIV,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

>>> design/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Start transfer emits the first pixel on the next cycle, then, unless the
// span is zero, a bit-serial divider forms the increments; no item is taken
// meanwhile. A tick runs the digit-serial add over the accumulator digits and
// then an emit state that loads the output register once it is free; no item
// is taken until that is done. Reset (rst_n, async, active low) leaves the block idle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
    import dda_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  item_t  item,
    output logic   pixel_valid,
    input  logic   pixel_ready,
    output pixel_t pixel
);

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [COORD_BITS-1:0]  span_reg, span_next;
    logic [STEPS_BITS-1:0]  steps_reg, steps_next;
    logic [COLOUR_BITS-1:0] colour_reg, colour_next;
    logic                   out_valid_reg, out_valid_next;
    pixel_t                 out_data_reg, out_data_next;

    axis_ctrl_t             ctrl;
    logic                   out_free;
    logic                   accept;
    logic                   start_acc;
    logic                   tick_acc;
    logic                   emit;
    logic [COORD_BITS-1:0]  mag_x, mag_y, span_new;
    logic [COORD_BITS-1:0]  coord_x, coord_y;

    assign out_free  = !out_valid_reg || pixel_ready;
    assign accept    = item_valid && item_ready;
    assign start_acc = accept && (item.cmd == CMD_START);
    assign tick_acc  = accept && (item.cmd == CMD_TICK) && (state_reg == ST_WAIT);
    assign span_new  = (mag_x >= mag_y) ? mag_x : mag_y;

    // axis datapaths
    dda_axis u_axis_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .p0    (item.start_x),
        .p1    (item.end_x),
        .span  (span_reg),
        .mag   (mag_x),
        .coord (coord_x)
    );

    dda_axis u_axis_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .p0    (item.start_y),
        .p1    (item.end_y),
        .span  (span_reg),
        .mag   (mag_y),
        .coord (coord_y)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE, ST_WAIT:
            begin
                if (start_acc)
                begin
                    state_next = (span_new == '0) ? ST_IDLE : ST_DIV;
                    cnt_next   = '0;
                end
                else if (tick_acc)
                begin
                    state_next = ST_ADD;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = ST_WAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ADD:
            begin
                if (cnt_reg == CNT_BITS'(ACC_DIGITS - 1))
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (steps_reg == '0) ? ST_IDLE : ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_ready     = 1'b0;
        emit           = 1'b0;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE, ST_WAIT:
            begin
                item_ready = out_free;
                ctrl.load  = start_acc;
            end
            ST_DIV:
            begin
                ctrl.div_en    = 1'b1;
                ctrl.div_first = (cnt_reg == '0);
            end
            ST_ADD:
            begin
                ctrl.add_en    = 1'b1;
                ctrl.add_first = (cnt_reg == '0);
            end
            ST_EMIT:
            begin
                emit = out_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // line registers and output register
    always_comb
    begin
        span_next      = span_reg;
        steps_next     = steps_reg;
        colour_next    = colour_reg;
        out_valid_next = out_valid_reg && !pixel_ready;
        out_data_next  = out_data_reg;
        if (start_acc)
        begin
            span_next                  = span_new;
            steps_next                 = STEPS_BITS'(span_new);
            colour_next                = item.colour;
            out_valid_next             = 1'b1;
            out_data_next.pixel_x      = item.start_x;
            out_data_next.pixel_y      = item.start_y;
            out_data_next.pixel_colour = item.colour;
            out_data_next.last_pixel   = (span_new == '0);
        end
        else if (tick_acc)
        begin
            steps_next = steps_reg - 1'b1;
        end
        else if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.pixel_x      = coord_x;
            out_data_next.pixel_y      = coord_y;
            out_data_next.pixel_colour = colour_reg;
            out_data_next.last_pixel   = (steps_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            span_reg      <= '0;
            steps_reg     <= '0;
            colour_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            span_reg      <= span_next;
            steps_reg     <= steps_next;
            colour_reg    <= colour_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_data_reg;

endmodule

>>> design/dda_axis.sv
// ----------------------------------------------------------------------------
// DDA axis datapath
// One coordinate axis: bit-serial restoring divider for the increment and a
// digit-serial accumulator that adds the signed increment on each tick.
// ----------------------------------------------------------------------------
module dda_axis
    import dda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  axis_ctrl_t            ctrl,
    input  logic [COORD_BITS-1:0] p0,
    input  logic [COORD_BITS-1:0] p1,
    input  logic [COORD_BITS-1:0] span,
    output logic [COORD_BITS-1:0] mag,
    output logic [COORD_BITS-1:0] coord
);

    logic [ACC_PAD-1:0]    acc_reg, acc_next;
    logic [ACC_PAD-1:0]    step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic                  carry_reg, carry_next;

    logic [REM_BITS-1:0]   trial;
    logic                  fits;
    logic [DIGIT_BITS-1:0] digit_op;
    logic                  cin;
    logic [DIGIT_BITS:0]   digit_sum;

    // span magnitude and current integer position
    assign mag   = (p1 >= p0) ? (p1 - p0) : (p0 - p1);
    assign coord = acc_reg[FRAC_BITS +: COORD_BITS];

    // divider trial subtract, first step uses the magnitude itself
    assign trial = ctrl.div_first ? rem_reg : {rem_reg[REM_BITS-2:0], 1'b0};
    assign fits  = (trial >= {1'b0, span});

    // serial add, a negative step is added as inverted digits plus carry in
    assign digit_op  = step_reg[DIGIT_BITS-1:0] ^ {DIGIT_BITS{neg_reg}};
    assign cin       = ctrl.add_first ? neg_reg : carry_reg;
    assign digit_sum = {1'b0, acc_reg[DIGIT_BITS-1:0]} + {1'b0, digit_op}
                     + {{DIGIT_BITS{1'b0}}, cin};

    // next state of the axis registers
    always_comb
    begin
        acc_next   = acc_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        carry_next = carry_reg;
        if (ctrl.load)
        begin
            acc_next   = ACC_PAD'(p0) << FRAC_BITS;
            step_next  = '0;
            neg_next   = (p1 < p0);
            rem_next   = {1'b0, mag};
            carry_next = 1'b0;
        end
        else if (ctrl.div_en)
        begin
            step_next = {step_reg[ACC_PAD-2:0], fits};
            rem_next  = fits ? (trial - {1'b0, span}) : trial;
        end
        else if (ctrl.add_en)
        begin
            acc_next   = {digit_sum[DIGIT_BITS-1:0], acc_reg[ACC_PAD-1:DIGIT_BITS]};
            step_next  = {step_reg[DIGIT_BITS-1:0], step_reg[ACC_PAD-1:DIGIT_BITS]};
            carry_next = digit_sum[DIGIT_BITS];
        end
    end

    // axis registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            step_reg  <= '0;
            neg_reg   <= 1'b0;
            rem_reg   <= '0;
            carry_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            neg_reg   <= neg_next;
            rem_reg   <= rem_next;
            carry_reg <= carry_next;
        end
    end

endmodule
